/* design/sensor_node_pair_ack_retry_assert.svh */
`ifndef SENSOR_NODE_PAIR_ACK_RETRY_ASSERT_SVH
`define SENSOR_NODE_PAIR_ACK_RETRY_ASSERT_SVH

// check an expression at every clock edge outside reset
`define SNPAR_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check a consequence in the cycle after its cause
`define SNPAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/snpar_pkg.sv */
package snpar_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int SEQ_BITS_DEFAULT  = 8;

    localparam int ADDR_BITS = 6;
    localparam int DATA_BITS = 64;

    localparam logic [2:0] REG_OWN_ADDRESS        = 3'd0;
    localparam logic [2:0] REG_PAIR_INTERVAL      = 3'd1;
    localparam logic [2:0] REG_HEARTBEAT_INTERVAL = 3'd2;
    localparam logic [2:0] REG_REPORT_INTERVAL    = 3'd3;
    localparam logic [2:0] REG_PAIR_ATTEMPT_LIMIT = 3'd4;
    localparam logic [2:0] REG_FAIL_NOTICE_ENABLE = 3'd5;

    localparam logic [31:0] PAIR_INTERVAL_RESET      = 32'd5000;
    localparam logic [31:0] HEARTBEAT_INTERVAL_RESET = 32'd60000;
    localparam logic [31:0] REPORT_INTERVAL_RESET    = 32'd60000;
    localparam logic [7:0]  PAIR_ATTEMPT_LIMIT_RESET = 8'd20;

    localparam int         ACK_WAIT_MS  = 300;
    localparam int         RETRY_GAP_MS = 50;
    localparam logic [1:0] TRY_COUNT    = 2'd3;

    localparam int RES_DEPTH = 4;

    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_PAIR_RESP = 3'd2;
    localparam logic [2:0] CMD_ACK       = 3'd3;
    localparam logic [2:0] CMD_NAK       = 3'd4;
    localparam logic [2:0] CMD_REPAIR    = 3'd5;
    localparam logic [2:0] CMD_PUBLISH   = 3'd6;

    localparam logic [2:0] KIND_PAIR_REQ  = 3'd0;
    localparam logic [2:0] KIND_DATA      = 3'd1;
    localparam logic [2:0] KIND_HEARTBEAT = 3'd2;
    localparam logic [2:0] KIND_FAILED    = 3'd3;
    localparam logic [2:0] KIND_PAIRED    = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] now_ms;
        logic [47:0] target_address;
        logic [7:0]  granted_slot;
        logic [7:0]  ack_sequence;
        logic        ack_denied;
        logic        nak_gateway_lost;
    } t_in_word;

    typedef struct packed {
        logic [2:0] emit_kind;
        logic [7:0] frame_sequence;
        logic [7:0] slot_number;
        logic       last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [47:0] own_address;
        logic [31:0] pair_interval;
        logic [31:0] heartbeat_interval;
        logic [31:0] report_interval;
        logic [7:0]  pair_attempt_limit;
        logic        fail_notice_enable;
    } t_cfg;

    typedef struct packed {
        logic [1:0]            count;
        t_out_word [1:0]       word;
    } t_push;

    function automatic t_out_word make_word(logic [2:0] kind, logic [7:0] seq,
                                            logic [7:0] slot);
        t_out_word w;
        w.emit_kind      = kind;
        w.frame_sequence = seq;
        w.slot_number    = slot;
        w.last_of_run    = 1'b0;
        return w;
    endfunction

endpackage

/* design/sensor_node_pair_ack_retry.sv */
// Node link controller for pairing and acknowledged sensor reports. Decoded
// events enter on the input channel; each is registered on acceptance and
// evaluated from that register once the result buffer has room, so one
// event is accepted every cycle while the input does not stall. An event
// causes zero, one or two result words; they pass through a four-word
// result buffer, and the input stalls only while fewer than two free places
// remain there. Registers sit at byte address 8*index on the 64-bit
// configuration port; the user must write them only while no event is in
// flight, and the block itself does not enforce this.
module sensor_node_pair_ack_retry #(
    parameter int TIME_BITS = snpar_pkg::TIME_BITS_DEFAULT,
    parameter int SEQ_BITS  = snpar_pkg::SEQ_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [snpar_pkg::ADDR_BITS-1:0] paddr,
    input  logic [snpar_pkg::DATA_BITS-1:0] pwdata,
    output logic [snpar_pkg::DATA_BITS-1:0] prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  snpar_pkg::t_in_word             i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output snpar_pkg::t_out_word            o_out_word
);

    snpar_pkg::t_cfg  cfg;
    snpar_pkg::t_push push;
    logic             room;

    snpar_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    snpar_link_core #(
        .TIME_BITS (TIME_BITS),
        .SEQ_BITS  (SEQ_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_room     (room),
        .o_push     (push)
    );

    snpar_result_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

/* design/snpar_cfg_regs.sv */
module snpar_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [snpar_pkg::ADDR_BITS-1:0] paddr,
    input  logic [snpar_pkg::DATA_BITS-1:0] pwdata,
    output logic [snpar_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output snpar_pkg::t_cfg                o_cfg
);

    snpar_pkg::t_cfg r_cfg;
    logic [2:0]      reg_idx;
    logic            wr_en;

    assign reg_idx = paddr[snpar_pkg::ADDR_BITS-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_address        <= '0;
            r_cfg.pair_interval      <= snpar_pkg::PAIR_INTERVAL_RESET;
            r_cfg.heartbeat_interval <= snpar_pkg::HEARTBEAT_INTERVAL_RESET;
            r_cfg.report_interval    <= snpar_pkg::REPORT_INTERVAL_RESET;
            r_cfg.pair_attempt_limit <= snpar_pkg::PAIR_ATTEMPT_LIMIT_RESET;
            r_cfg.fail_notice_enable <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                snpar_pkg::REG_OWN_ADDRESS:        r_cfg.own_address <= pwdata[47:0];
                snpar_pkg::REG_PAIR_INTERVAL:      r_cfg.pair_interval <= pwdata[31:0];
                snpar_pkg::REG_HEARTBEAT_INTERVAL: r_cfg.heartbeat_interval <= pwdata[31:0];
                snpar_pkg::REG_REPORT_INTERVAL:    r_cfg.report_interval <= pwdata[31:0];
                snpar_pkg::REG_PAIR_ATTEMPT_LIMIT: r_cfg.pair_attempt_limit <= pwdata[7:0];
                snpar_pkg::REG_FAIL_NOTICE_ENABLE: r_cfg.fail_notice_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            snpar_pkg::REG_OWN_ADDRESS:        prdata = {16'd0, r_cfg.own_address};
            snpar_pkg::REG_PAIR_INTERVAL:      prdata = {32'd0, r_cfg.pair_interval};
            snpar_pkg::REG_HEARTBEAT_INTERVAL: prdata = {32'd0, r_cfg.heartbeat_interval};
            snpar_pkg::REG_REPORT_INTERVAL:    prdata = {32'd0, r_cfg.report_interval};
            snpar_pkg::REG_PAIR_ATTEMPT_LIMIT: prdata = {56'd0, r_cfg.pair_attempt_limit};
            snpar_pkg::REG_FAIL_NOTICE_ENABLE: prdata = {63'd0, r_cfg.fail_notice_enable};
            default:                           prdata = '0;
        endcase
    end

endmodule

/* design/snpar_link_core.sv */
module snpar_link_core #(
    parameter int TIME_BITS = snpar_pkg::TIME_BITS_DEFAULT,
    parameter int SEQ_BITS  = snpar_pkg::SEQ_BITS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  snpar_pkg::t_cfg     i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  snpar_pkg::t_in_word i_in_word,
    input  logic                i_room,
    output snpar_pkg::t_push    o_push
);

    localparam int TW = TIME_BITS;
    localparam int SW = SEQ_BITS;
    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int WW = (SEQ_BITS > 8) ? SEQ_BITS : 8;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_DELAY = 2'd2,
        PH_RWAIT = 2'd3
    } t_phase;

    logic                r_in_valid;
    snpar_pkg::t_in_word r_in;

    logic          r_running,   n_running;
    logic          r_paired,    n_paired;
    logic [7:0]    r_attempt,   n_attempt;
    logic [SW-1:0] r_next_seq,  n_next_seq;
    logic [SW-1:0] r_awaited,   n_awaited;
    logic [7:0]    r_slot,      n_slot;
    t_phase        r_phase,     n_phase;
    logic [1:0]    r_tries,     n_tries;
    logic          r_ack_seen,  n_ack_seen;
    logic [TW-1:0] r_last_pair, n_last_pair;
    logic [TW-1:0] r_last_hb,   n_last_hb;
    logic [TW-1:0] r_last_rep,  n_last_rep;
    logic [TW-1:0] r_deadline,  n_deadline;
    logic [TW-1:0] r_retry,     n_retry;

    logic             fire;
    logic [CW-1:0]    now_w;
    logic [TW-1:0]    now_t;
    logic [TW-1:0]    d_pair, d_hb, d_rep;
    logic             pair_due, hb_due, rep_due;
    logic [SW-1:0]    seq1;
    logic [1:0]       tries_dec;
    snpar_pkg::t_push push;

    function automatic logic [7:0] seq8(logic [SW-1:0] s);
        logic [WW-1:0] w;
        w = WW'(s);
        return w[7:0];
    endfunction

    assign fire       = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !i_room;
    assign o_push     = push;

    assign now_w    = CW'(r_in.now_ms);
    assign now_t    = now_w[TW-1:0];
    assign d_pair   = now_t - r_last_pair;
    assign d_hb     = now_t - r_last_hb;
    assign d_rep    = now_t - r_last_rep;
    assign pair_due = CW'(d_pair) >= CW'(i_cfg.pair_interval);
    assign hb_due   = CW'(d_hb) >= CW'(i_cfg.heartbeat_interval);
    assign rep_due  = CW'(d_rep) >= CW'(i_cfg.report_interval);
    assign seq1     = r_next_seq + SW'(1);
    assign tries_dec = r_tries - 2'd1;

    always_comb begin
        n_running   = r_running;
        n_paired    = r_paired;
        n_attempt   = r_attempt;
        n_next_seq  = r_next_seq;
        n_awaited   = r_awaited;
        n_slot      = r_slot;
        n_phase     = r_phase;
        n_tries     = r_tries;
        n_ack_seen  = r_ack_seen;
        n_last_pair = r_last_pair;
        n_last_hb   = r_last_hb;
        n_last_rep  = r_last_rep;
        n_deadline  = r_deadline;
        n_retry     = r_retry;
        push        = '0;

        if (fire) begin
            unique case (r_in.cmd)
                snpar_pkg::CMD_TICK: begin
                    if (r_running && !r_paired) begin
                        if (pair_due && (r_attempt < i_cfg.pair_attempt_limit)) begin
                            n_last_pair   = now_t;
                            n_attempt     = r_attempt + 8'd1;
                            n_next_seq    = seq1;
                            push.count    = 2'd1;
                            push.word[0]  = snpar_pkg::make_word(snpar_pkg::KIND_PAIR_REQ,
                                                                 seq8(r_next_seq), 8'd0);
                        end else if ((r_attempt >= i_cfg.pair_attempt_limit) &&
                                     i_cfg.fail_notice_enable) begin
                            n_attempt    = 8'd0;
                            n_last_pair  = '0;
                            push.count   = 2'd1;
                            push.word[0] = snpar_pkg::make_word(snpar_pkg::KIND_FAILED,
                                                                8'd0, 8'd0);
                        end
                    end else if (r_running) begin
                        unique case (r_phase)
                            PH_IDLE: begin
                                if (rep_due) begin
                                    n_last_rep   = now_t;
                                    n_awaited    = r_next_seq;
                                    n_phase      = PH_WAIT;
                                    n_deadline   = now_t + TW'(snpar_pkg::ACK_WAIT_MS);
                                    n_tries      = snpar_pkg::TRY_COUNT;
                                    n_ack_seen   = 1'b0;
                                    push.word[0] = snpar_pkg::make_word(snpar_pkg::KIND_DATA,
                                                                        seq8(r_next_seq), 8'd0);
                                end
                                if (hb_due) begin
                                    n_last_hb = now_t;
                                    if (rep_due) begin
                                        push.word[1] = snpar_pkg::make_word(
                                            snpar_pkg::KIND_HEARTBEAT, seq8(seq1), 8'd0);
                                    end else begin
                                        push.word[0] = snpar_pkg::make_word(
                                            snpar_pkg::KIND_HEARTBEAT, seq8(r_next_seq), 8'd0);
                                    end
                                end
                                push.count = {1'b0, rep_due} + {1'b0, hb_due};
                                n_next_seq = r_next_seq + SW'(push.count);
                            end
                            PH_DELAY: begin
                                if (now_t >= r_retry) begin
                                    n_awaited    = r_next_seq;
                                    n_next_seq   = seq1;
                                    n_phase      = PH_RWAIT;
                                    n_deadline   = now_t + TW'(snpar_pkg::ACK_WAIT_MS);
                                    n_ack_seen   = 1'b0;
                                    push.count   = 2'd1;
                                    push.word[0] = snpar_pkg::make_word(snpar_pkg::KIND_DATA,
                                                                        seq8(r_next_seq), 8'd0);
                                end
                            end
                            PH_WAIT, PH_RWAIT: begin
                                if (r_ack_seen) begin
                                    n_phase = PH_IDLE;
                                end else if (now_t >= r_deadline) begin
                                    n_tries = tries_dec;
                                    if (tries_dec != 2'd0) begin
                                        n_phase = PH_DELAY;
                                        n_retry = now_t + TW'(snpar_pkg::RETRY_GAP_MS);
                                    end else begin
                                        n_paired    = 1'b0;
                                        n_attempt   = 8'd0;
                                        n_last_pair = '0;
                                        n_phase     = PH_IDLE;
                                    end
                                end
                            end
                        endcase
                    end
                end
                snpar_pkg::CMD_START: begin
                    n_running    = 1'b1;
                    n_paired     = 1'b0;
                    n_attempt    = 8'd0;
                    n_last_pair  = '0;
                    n_last_hb    = '0;
                    n_last_rep   = '0;
                    n_ack_seen   = 1'b0;
                    n_tries      = 2'd0;
                    n_next_seq   = SW'(1);
                    n_phase      = PH_IDLE;
                    push.count   = 2'd1;
                    push.word[0] = snpar_pkg::make_word(snpar_pkg::KIND_PAIR_REQ, 8'd0, 8'd0);
                end
                snpar_pkg::CMD_PAIR_RESP: begin
                    if (r_running && (r_in.target_address == i_cfg.own_address)) begin
                        n_paired     = 1'b1;
                        n_slot       = r_in.granted_slot;
                        n_attempt    = 8'd0;
                        n_last_rep   = '0;
                        push.count   = 2'd1;
                        push.word[0] = snpar_pkg::make_word(snpar_pkg::KIND_PAIRED, 8'd0,
                                                            r_in.granted_slot);
                    end
                end
                snpar_pkg::CMD_ACK: begin
                    if (r_running && (WW'(r_in.ack_sequence) == WW'(r_awaited))) begin
                        n_ack_seen = 1'b1;
                        if (r_in.ack_denied) begin
                            n_paired    = 1'b0;
                            n_attempt   = 8'd0;
                            n_last_pair = '0;
                            n_phase     = PH_IDLE;
                        end
                    end
                end
                snpar_pkg::CMD_NAK: begin
                    if (r_running && r_in.nak_gateway_lost) begin
                        n_paired    = 1'b0;
                        n_attempt   = 8'd0;
                        n_last_pair = '0;
                        n_phase     = PH_IDLE;
                    end
                end
                snpar_pkg::CMD_REPAIR: begin
                    n_paired    = 1'b0;
                    n_attempt   = 8'd0;
                    n_last_pair = '0;
                    n_phase     = PH_IDLE;
                end
                snpar_pkg::CMD_PUBLISH: begin
                    if (r_paired) begin
                        n_last_rep = '0;
                    end
                end
                default: ;
            endcase

            if (push.count == 2'd1) begin
                push.word[0].last_of_run = 1'b1;
            end else if (push.count == 2'd2) begin
                push.word[1].last_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_running   <= 1'b0;
            r_paired    <= 1'b0;
            r_attempt   <= '0;
            r_next_seq  <= '0;
            r_awaited   <= '0;
            r_slot      <= '0;
            r_phase     <= PH_IDLE;
            r_tries     <= '0;
            r_ack_seen  <= 1'b0;
            r_last_pair <= '0;
            r_last_hb   <= '0;
            r_last_rep  <= '0;
            r_deadline  <= '0;
            r_retry     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            r_running   <= n_running;
            r_paired    <= n_paired;
            r_attempt   <= n_attempt;
            r_next_seq  <= n_next_seq;
            r_awaited   <= n_awaited;
            r_slot      <= n_slot;
            r_phase     <= n_phase;
            r_tries     <= n_tries;
            r_ack_seen  <= n_ack_seen;
            r_last_pair <= n_last_pair;
            r_last_hb   <= n_last_hb;
            r_last_rep  <= n_last_rep;
            r_deadline  <= n_deadline;
            r_retry     <= n_retry;
        end
    end

endmodule

/* design/snpar_result_fifo.sv */
`include "sensor_node_pair_ack_retry_assert.svh"

module snpar_result_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  snpar_pkg::t_push     i_push,
    output logic                 o_room,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output snpar_pkg::t_out_word o_out_word
);

    localparam int DEPTH    = snpar_pkg::RES_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    snpar_pkg::t_out_word r_mem [DEPTH];
    logic [PTR_BITS-1:0]  r_wr, r_rd;
    logic [CNT_BITS-1:0]  r_count;
    logic [PTR_BITS-1:0]  wr_next;
    logic                 pop;

    assign wr_next     = r_wr + PTR_BITS'(1);
    assign o_out_valid = r_count != '0;
    assign o_out_word  = r_mem[r_rd];
    assign pop         = o_out_valid && !i_out_stall;
    assign o_room      = r_count <= CNT_BITS'(DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.word[0];
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.word[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_BITS'(i_push.count);
            r_rd    <= r_rd + PTR_BITS'(pop);
            r_count <= r_count + CNT_BITS'(i_push.count) - CNT_BITS'(pop);
        end
    end

    `SNPAR_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_BITS'(DEPTH), "result buffer overflow")
    `SNPAR_ASSERT_ALWAYS(a_push_room, i_clk, i_rst_n, (i_push.count == 2'd0) || o_room, "push without room")
    `SNPAR_ASSERT_ALWAYS(a_last_mark, i_clk, i_rst_n, (i_push.count != 2'd2) || (i_push.word[1].last_of_run && !i_push.word[0].last_of_run), "run end mark misplaced")
    `SNPAR_ASSERT_NEXT(a_pop_drain, i_clk, i_rst_n, pop && (i_push.count == 2'd0), r_count == $past(r_count) - 1'b1, "pop did not drain")

endmodule

/* tb/sensor_node_pair_ack_retry_tb.sv */
`timescale 1ns / 100ps

module sensor_node_pair_ack_retry_tb;
    import snpar_pkg::*;

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 125;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam t_out_word NO_WORD = '0;

    typedef enum logic [1:0] {
        LINK_IDLE,
        LINK_WAIT_ACK,
        LINK_RETRY_GAP,
        LINK_RETRY_WAIT
    } t_link_phase;

    typedef struct packed {
        t_in_word  w;
        logic      typed;
        logic      has_word;
        t_out_word word;
    } t_step;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_word = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_word;

    sensor_node_pair_ack_retry dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // register copies
    logic [47:0] cfg_own_addr = '0;
    logic [31:0] cfg_pair_iv = PAIR_INTERVAL_RESET;
    logic [31:0] cfg_hb_iv = HEARTBEAT_INTERVAL_RESET;
    logic [31:0] cfg_report_iv = REPORT_INTERVAL_RESET;
    logic [7:0]  cfg_limit = PAIR_ATTEMPT_LIMIT_RESET;
    logic        cfg_notice = 1'b1;

    // link state
    logic        running = 1'b0;
    logic        paired = 1'b0;
    logic [7:0]  attempts = '0;
    logic [7:0]  next_seq = '0;
    logic [7:0]  awaited_seq = '0;
    logic [7:0]  slot_held = '0;
    t_link_phase link_phase = LINK_IDLE;
    logic [1:0]  tries = '0;
    logic        ack_seen = 1'b0;
    logic [31:0] last_pair_ms = '0;
    logic [31:0] last_hb_ms = '0;
    logic [31:0] last_report_ms = '0;
    logic [31:0] ack_deadline = '0;
    logic [31:0] retry_ms = '0;

    t_out_word pending_words[$];
    t_step     script[$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    int        stall_left = 0;
    bit        gaps_on = 1'b1;
    logic [31:0] clock_ms = 32'd300;
    t_out_word head_word;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic drop_link();
        paired = 1'b0;
        attempts = '0;
        last_pair_ms = '0;
        link_phase = LINK_IDLE;
    endtask

    task automatic link_predict(input t_in_word w, output logic [1:0] n,
                                output t_out_word [1:0] res);
        logic [31:0] now;
        now = w.now_ms;
        n = 2'd0;
        res = '0;
        case (w.cmd)
            CMD_TICK: begin
                if (running && !paired) begin
                    if ((now - last_pair_ms) >= cfg_pair_iv && attempts < cfg_limit) begin
                        last_pair_ms = now;
                        attempts = attempts + 8'd1;
                        res[n] = {KIND_PAIR_REQ, next_seq, 8'd0, 1'b0};
                        next_seq = next_seq + 8'd1;
                        n = n + 2'd1;
                    end else if (attempts >= cfg_limit && cfg_notice) begin
                        attempts = '0;
                        last_pair_ms = '0;
                        res[n] = {KIND_FAILED, 8'd0, 8'd0, 1'b0};
                        n = n + 2'd1;
                    end
                end else if (running) begin
                    case (link_phase)
                        LINK_IDLE: begin
                            if ((now - last_report_ms) >= cfg_report_iv) begin
                                last_report_ms = now;
                                awaited_seq = next_seq;
                                res[n] = {KIND_DATA, next_seq, 8'd0, 1'b0};
                                next_seq = next_seq + 8'd1;
                                n = n + 2'd1;
                                link_phase = LINK_WAIT_ACK;
                                ack_deadline = now + ACK_WAIT_MS;
                                tries = TRY_COUNT;
                                ack_seen = 1'b0;
                            end
                            if ((now - last_hb_ms) >= cfg_hb_iv) begin
                                last_hb_ms = now;
                                res[n] = {KIND_HEARTBEAT, next_seq, 8'd0, 1'b0};
                                next_seq = next_seq + 8'd1;
                                n = n + 2'd1;
                            end
                        end
                        LINK_RETRY_GAP: begin
                            if (now >= retry_ms) begin
                                awaited_seq = next_seq;
                                res[n] = {KIND_DATA, next_seq, 8'd0, 1'b0};
                                next_seq = next_seq + 8'd1;
                                n = n + 2'd1;
                                link_phase = LINK_RETRY_WAIT;
                                ack_deadline = now + ACK_WAIT_MS;
                                ack_seen = 1'b0;
                            end
                        end
                        default: begin
                            if (ack_seen) begin
                                link_phase = LINK_IDLE;
                            end else if (now >= ack_deadline) begin
                                tries = tries - 2'd1;
                                if (tries != 2'd0) begin
                                    link_phase = LINK_RETRY_GAP;
                                    retry_ms = now + RETRY_GAP_MS;
                                end else begin
                                    drop_link();
                                end
                            end
                        end
                    endcase
                end
            end
            CMD_START: begin
                running = 1'b1;
                paired = 1'b0;
                attempts = '0;
                last_pair_ms = '0;
                last_hb_ms = '0;
                last_report_ms = '0;
                ack_seen = 1'b0;
                tries = '0;
                link_phase = LINK_IDLE;
                res[n] = {KIND_PAIR_REQ, 8'd0, 8'd0, 1'b0};
                next_seq = 8'd1;
                n = n + 2'd1;
            end
            CMD_PAIR_RESP: begin
                if (running && w.target_address == cfg_own_addr) begin
                    paired = 1'b1;
                    slot_held = w.granted_slot;
                    attempts = '0;
                    last_report_ms = '0;
                    res[n] = {KIND_PAIRED, 8'd0, slot_held, 1'b0};
                    n = n + 2'd1;
                end
            end
            CMD_ACK: begin
                if (running && w.ack_sequence == awaited_seq) begin
                    ack_seen = 1'b1;
                    if (w.ack_denied) drop_link();
                end
            end
            CMD_NAK: begin
                if (running && w.nak_gateway_lost) drop_link();
            end
            CMD_REPAIR: drop_link();
            CMD_PUBLISH: begin
                if (paired) last_report_ms = '0;
            end
            default: ;
        endcase
        if (n != 2'd0) res[n - 2'd1].last_of_run = 1'b1;
    endtask

    function automatic t_in_word evt(logic [2:0] cmd, logic [31:0] now, logic [47:0] target,
                                     logic [7:0] slot, logic [7:0] seq, logic denied,
                                     logic lost);
        evt = {cmd, now, target, slot, seq, denied, lost};
    endfunction

    task automatic add_step(input t_in_word w, input logic typed, input logic has_word,
                            input t_out_word word);
        script.push_back({w, typed, has_word, word});
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_OWN_ADDRESS:        cfg_own_addr = data[47:0];
            REG_PAIR_INTERVAL:      cfg_pair_iv = data[31:0];
            REG_HEARTBEAT_INTERVAL: cfg_hb_iv = data[31:0];
            REG_REPORT_INTERVAL:    cfg_report_iv = data[31:0];
            REG_PAIR_ATTEMPT_LIMIT: cfg_limit = data[7:0];
            REG_FAIL_NOTICE_ENABLE: cfg_notice = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge i_clk);
    endtask

    task automatic offer_word(input t_in_word w, input logic typed, input logic has_word,
                              input t_out_word word);
        logic [1:0]      n;
        t_out_word [1:0] res;
        int              gap;
        int              k;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word = w;
        do @(posedge i_clk); while (o_in_stall);
        link_predict(w, n, res);
        if (typed) begin
            if (has_word) pending_words.push_back(word);
        end else begin
            for (k = 0; k < int'(n); k++) pending_words.push_back(res[k]);
        end
        @(negedge i_clk);
    endtask

    task automatic drain_results(input int settle);
        i_in_valid = 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic next_random_word(output t_in_word w);
        int          roll;
        logic [31:0] hi;
        hi = $urandom;
        w.cmd = CMD_TICK;
        w.now_ms = $urandom;
        w.target_address = {hi[15:0], $urandom};
        w.granted_slot = hi[23:16];
        w.ack_sequence = hi[31:24];
        w.ack_denied = 1'($urandom_range(0, 1));
        w.nak_gateway_lost = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (!running && roll < 70) begin
            w.cmd = CMD_START;
        end else if (roll < 54) begin
            roll = $urandom_range(0, 19);
            if (roll < 8) clock_ms = clock_ms + $urandom_range(0, 60);
            else if (roll < 14) clock_ms = clock_ms + $urandom_range(0, 400);
            else if (roll < 18) clock_ms = clock_ms + $urandom_range(0, 3000);
            else if (roll < 19) clock_ms = $urandom;
            else clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
            w.now_ms = clock_ms;
        end else if (roll < 62) begin
            w.cmd = CMD_PAIR_RESP;
            if ($urandom_range(0, 4) != 0) w.target_address = cfg_own_addr;
        end else if (roll < 74) begin
            w.cmd = CMD_ACK;
            if ($urandom_range(0, 4) != 0) w.ack_sequence = awaited_seq;
            w.ack_denied = ($urandom_range(0, 6) == 0);
        end else if (roll < 78) begin
            w.cmd = CMD_NAK;
        end else if (roll < 80) begin
            w.cmd = CMD_REPAIR;
        end else if (roll < 86) begin
            w.cmd = CMD_PUBLISH;
        end else if (roll < 88) begin
            w.cmd = CMD_UNUSED;
        end else if (roll < 90) begin
            w.cmd = CMD_START;
        end else begin
            w.cmd = 3'($urandom_range(0, 7));
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_out_stall = 1'b1;
            stall_left = stall_left - 1;
        end else if (i_out_stall) begin
            i_out_stall = 1'b0;
        end else if (gaps_on && $urandom_range(0, 9) == 0) begin
            i_out_stall = 1'b1;
            stall_left = $urandom_range(0, 15);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $display("%0t: word with nothing expected: kind=%0d seq=%0d slot=%0d last=%0d",
                         $time, o_out_word.emit_kind, o_out_word.frame_sequence,
                         o_out_word.slot_number, o_out_word.last_of_run);
                mismatch_count++;
            end else begin
                head_word = pending_words.pop_front();
                if (o_out_word.emit_kind !== head_word.emit_kind ||
                    o_out_word.frame_sequence !== head_word.frame_sequence ||
                    o_out_word.slot_number !== head_word.slot_number ||
                    o_out_word.last_of_run !== head_word.last_of_run) begin
                    $display("%0t: expected kind=%0d seq=%0d slot=%0d last=%0d, got kind=%0d seq=%0d slot=%0d last=%0d",
                             $time, head_word.emit_kind, head_word.frame_sequence,
                             head_word.slot_number, head_word.last_of_run,
                             o_out_word.emit_kind, o_out_word.frame_sequence,
                             o_out_word.slot_number, o_out_word.last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sensor_node_pair_ack_retry_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          p;
        int          k;
        t_in_word    w;
        logic [31:0] hi;
        logic [47:0] addr;
        logic [31:0] piv;
        logic [31:0] hiv;
        logic [31:0] riv;
        logic [7:0]  lim;
        logic        ntc;

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // nothing moves before a start, repair included
        add_step(evt(CMD_TICK, 32'd0, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b1, 1'b0, NO_WORD);
        add_step(evt(CMD_PAIR_RESP, 32'd0, 48'd0, 8'd255, 8'd0, 1'b0, 1'b0),
                 1'b1, 1'b0, NO_WORD);
        add_step(evt(CMD_ACK, 32'd0, 48'd0, 8'd0, 8'd255, 1'b1, 1'b0), 1'b1, 1'b0, NO_WORD);
        add_step(evt(CMD_NAK, 32'd0, 48'd0, 8'd0, 8'd0, 1'b0, 1'b1), 1'b1, 1'b0, NO_WORD);
        add_step(evt(CMD_REPAIR, 32'd0, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b1, 1'b0, NO_WORD);
        add_step(evt(CMD_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'd255, 8'd255, 1'b1, 1'b1),
                 1'b1, 1'b0, NO_WORD);
        add_step(evt(CMD_START, 32'd0, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0),
                 1'b1, 1'b1, {KIND_PAIR_REQ, 8'd0, 8'd0, 1'b1});
        add_step(evt(CMD_TICK, 32'd4999, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_TICK, 32'd5000, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_PAIR_RESP, 32'd0, 48'hFFFF_FFFF_FFFF, 8'd7, 8'd0, 1'b0, 1'b0),
                 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_PAIR_RESP, 32'd0, 48'd0, 8'd255, 8'd0, 1'b0, 1'b0),
                 1'b1, 1'b1, {KIND_PAIRED, 8'd0, 8'd255, 1'b1});
        add_step(evt(CMD_PUBLISH, 32'd0, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_TICK, 32'd60000, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_TICK, 32'd60300, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_TICK, 32'd60350, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_ACK, 32'd0, 48'd0, 8'd0, 8'd4, 1'b0, 1'b0), 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_TICK, 32'd60650, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_TICK, 32'hFFFF_FFFF, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0),
                 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_TICK, 32'd0, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_TICK, 32'd299, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_NAK, 32'd0, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0), 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_ACK, 32'd0, 48'd0, 8'd0, 8'd5, 1'b1, 1'b0), 1'b0, 1'b0, NO_WORD);
        add_step(evt(CMD_PAIR_RESP, 32'd0, 48'd0, 8'd0, 8'd0, 1'b0, 1'b0),
                 1'b1, 1'b1, {KIND_PAIRED, 8'd0, 8'd0, 1'b1});
        add_step(evt(CMD_NAK, 32'd0, 48'd0, 8'd0, 8'd0, 1'b0, 1'b1), 1'b0, 1'b0, NO_WORD);

        for (k = 0; k < script.size(); k++)
            offer_word(script[k].w, script[k].typed, script[k].has_word, script[k].word);

        for (p = 0; p < PHASE_COUNT; p++) begin
            drain_results(SETTLE_CYCLES);
            hi = $urandom;
            addr = {hi[15:0], $urandom};
            case (p)
                0: begin
                    piv = 32'd200; hiv = 32'd800; riv = 32'd400; lim = 8'd4; ntc = 1'b1;
                end
                1: begin
                    addr = '0; piv = '0; hiv = '0; riv = '0; lim = 8'd0; ntc = 1'b1;
                end
                2: begin
                    addr = '1; piv = '1; hiv = '1; riv = '1; lim = 8'd255; ntc = 1'b0;
                end
                3: begin
                    piv = 32'd50; hiv = 32'd300; riv = 32'd100; lim = 8'd1; ntc = 1'b0;
                end
                default: begin
                    piv = $urandom_range(0, 1000);
                    hiv = $urandom_range(0, 3000);
                    riv = $urandom_range(0, 1500);
                    lim = 8'($urandom_range(0, 6));
                    ntc = 1'($urandom_range(0, 1));
                end
            endcase
            gaps_on = (p != 3) && (p != PHASE_COUNT - 1);
            cfg_write(REG_OWN_ADDRESS, {16'd0, addr});
            cfg_write(REG_PAIR_INTERVAL, {32'd0, piv});
            cfg_write(REG_HEARTBEAT_INTERVAL, {32'd0, hiv});
            cfg_write(REG_REPORT_INTERVAL, {32'd0, riv});
            cfg_write(REG_PAIR_ATTEMPT_LIMIT, {56'd0, lim});
            cfg_write(REG_FAIL_NOTICE_ENABLE, {63'd0, ntc});
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == PHASE_ITEMS / 2) drain_results(0);
                next_random_word(w);
                offer_word(w, 1'b0, 1'b0, NO_WORD);
            end
        end

        drain_results(DRAIN_CYCLES);
        if (mismatch_count == 0) begin
            $display("sensor_node_pair_ack_retry_tb: clean");
        end else begin
            $display("sensor_node_pair_ack_retry_tb: errors");
        end
        $finish;
    end

endmodule

/* sensor_node_pair_ack_retry.f */
+incdir+design
design/snpar_pkg.sv
design/snpar_cfg_regs.sv
design/snpar_link_core.sv
design/snpar_result_fifo.sv
design/sensor_node_pair_ack_retry.sv
tb/sensor_node_pair_ack_retry_tb.sv
